/* design/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 byte stream decoder.
package utf8d_pkg;

	localparam int CP_W = 21;
	localparam int ST_W = 2;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = $clog2(OQ_DEPTH);
	localparam int OQ_LW = $clog2(OQ_DEPTH + 1);

	localparam logic [ST_W-1:0] ST_VALID   = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
	localparam logic [ST_W-1:0] ST_END     = 2'd2;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic [ST_W-1:0] status;
		logic            last;
	} result_t;

	// up to two results per byte; cnt says how many are live
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} dec_t;

	typedef struct packed {
		logic [OQ_LW-1:0] level;
		logic             space2;
	} oq_stat_t;

endpackage

/* design/utf8d_decode.sv */
// Byte decode logic and sequence state (pending count, partial code point).
module utf8d_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       byte_in,
	input  logic             advance,
	output utf8d_pkg::dec_t  dec
);
	import utf8d_pkg::*;

	typedef struct packed {
		logic            has;
		result_t         res;
		logic [1:0]      pend;
		logic [CP_W-1:0] part;
	} lead_t;

	logic [1:0]      pend_q;
	logic [CP_W-1:0] part_q;
	logic [1:0]      pend_d;
	logic [CP_W-1:0] part_d;
	logic [CP_W-1:0] shifted;
	logic [1:0]      pend_dec;
	lead_t           lead;

	function automatic lead_t take_lead(input logic [7:0] b);
		lead_t l;
		l.has = 1'b0;
		l.res = '{code_point: '0, status: ST_INVALID, last: 1'b1};
		l.pend = 2'd0;
		l.part = '0;
		if (b == 8'h00) begin
			l.has = 1'b1;
			l.res.status = ST_END;
		end else if (b[7] == 1'b0) begin
			l.has = 1'b1;
			l.res.status = ST_VALID;
			l.res.code_point = CP_W'(b);
		end else if (b[7:5] == 3'b110) begin
			l.pend = 2'd1;
			l.part = CP_W'(b[4:0]);
		end else if (b[7:4] == 4'b1110) begin
			l.pend = 2'd2;
			l.part = CP_W'(b[3:0]);
		end else if (b[7:3] == 5'b11110) begin
			l.pend = 2'd3;
			l.part = CP_W'(b[2:0]);
		end else begin
			l.has = 1'b1;
		end
		return l;
	endfunction

	assign lead = take_lead(byte_in);
	assign shifted = {part_q[CP_W-7:0], byte_in[5:0]};
	assign pend_dec = pend_q - 2'd1;

	always_comb begin
		dec.cnt = 2'd0;
		dec.r0 = lead.res;
		dec.r1 = lead.res;
		pend_d = lead.pend;
		part_d = lead.part;
		if (pend_q != 2'd0) begin
			if (byte_in[7:6] == 2'b10) begin
				pend_d = pend_dec;
				part_d = shifted;
				if (pend_dec == 2'd0) begin
					part_d = '0;
					dec.cnt = 2'd1;
					dec.r0.last = 1'b1;
					if (shifted == '0) begin
						dec.r0.status = ST_INVALID;
						dec.r0.code_point = '0;
					end else begin
						dec.r0.status = ST_VALID;
						dec.r0.code_point = shifted;
					end
				end
			end else begin
				// broken sequence: flag it, then retry the byte as a lead
				dec.r0 = '{code_point: '0, status: ST_INVALID, last: !lead.has};
				dec.cnt = lead.has ? 2'd2 : 2'd1;
			end
		end else begin
			dec.cnt = {1'b0, lead.has};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			part_q <= '0;
		end else if (advance) begin
			pend_q <= pend_d;
			part_q <= part_d;
		end
	end

endmodule

/* design/utf8d_outq.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle while pop is high.
module utf8d_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utf8d_pkg::dec_t     dec,
	input  logic                pop,
	output utf8d_pkg::result_t  head,
	output utf8d_pkg::oq_stat_t stat
);
	import utf8d_pkg::*;

	result_t          mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q;
	logic [OQ_AW-1:0] rd_q;
	logic [OQ_LW-1:0] level_q;
	logic [1:0]       n_push;
	logic             do_pop;

	assign n_push = push ? dec.cnt : 2'd0;
	assign do_pop = pop && (level_q != '0);
	assign head = mem[rd_q];
	assign stat.level = level_q;
	assign stat.space2 = level_q <= OQ_LW'(OQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem[wr_q] <= dec.r0;
		end
		if (n_push == 2'd2) begin
			mem[wr_q + OQ_AW'(1)] <= dec.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			wr_q <= wr_q + OQ_AW'(n_push);
			rd_q <= rd_q + OQ_AW'(do_pop);
			level_q <= level_q + OQ_LW'(n_push) - OQ_LW'(do_pop);
		end
	end

endmodule

/* design/utf8_byte_stream_decoder.sv */
// Top level of the UTF-8 byte stream decoder.
// Takes one UTF-8 byte per item and emits decoded code points with a status
// (valid, invalid, end of text); tlast marks the final result of each byte.
// Throughput is one byte per cycle while two result queue slots are free.
// A byte that breaks an open sequence and is itself a complete character
// gives two results; the four-entry result
// queue absorbs these, and input stalls only when fewer than two queue slots
// are free. No overlong or range checks are made; a decoded zero is invalid.
module utf8_byte_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast    // last_of_run
);
	import utf8d_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	dec_t       dec;
	result_t    head;
	oq_stat_t   stat;

	assign advance = valid_s1 && stat.space2;
	assign s_axis_tready = !valid_s1 || stat.space2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	utf8d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_s1),
		.advance (advance),
		.dec     (dec)
	);

	utf8d_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.dec    (dec),
		.pop    (m_axis_tready),
		.head   (head),
		.stat   (stat)
	);

	assign m_axis_tvalid = stat.level != '0;
	assign m_axis_tdata = {3'b000, head.code_point};
	assign m_axis_tuser = head.status;
	assign m_axis_tlast = head.last;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= OQ_LW'(OQ_DEPTH))
		else $error("result queue overflow");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stage 1 item lost while stalled");

	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_VALID |-> m_axis_tdata[20:0] == '0)
		else $error("code point not zero on non-valid result");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_END |-> m_axis_tlast)
		else $error("end of text result without tlast");

endmodule
